### rtl/imufd_pkg.sv
package imufd_pkg;

    // Frame layout.
    localparam int unsigned FRAME_LENGTH = 11;
    localparam int unsigned POS_WIDTH    = 4;
    localparam int unsigned STORE_DEPTH  = 7;
    localparam logic [7:0]  HEADER_BYTE  = 8'h55;

    // Frame type codes carried in byte 1.
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Result kind codes.
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    // Plus and minus 90 degrees in raw angle units.
    localparam logic signed [15:0] YAW_POS_LIMIT = 16'sd16384;
    localparam logic signed [15:0] YAW_NEG_LIMIT = -16'sd16384;

    // Default depth of the queue between framer and turn tracker.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // One decoded frame on its way to the back end.
    typedef struct packed {
        logic [15:0] axis_z;
        logic [15:0] axis_y;
        logic [15:0] axis_x;
        logic [1:0]  frame_kind;
    } imufd_item_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } imufd_q_status_t;

endpackage

### rtl/imu_serial_frame_decoder.sv
// Decoder for the 11-byte serial frames of an inertial sensor.
// The slave stream takes one received byte per transaction on s_tdata. The
// decoder hunts for header byte 0x55, collects the frame, and checks the last
// byte against the low 8 bits of the sum of the first ten. A good frame of
// type acceleration, angular rate or angle gives one master transaction with
// the kind, three raw signed axes and a 32-bit wrapping turn counter that
// follows yaw across the 180 degree seam. Other frames give nothing.
// Throughput: one byte per clock cycle while the queue is not full. The
// accepted checksum byte writes the frame into the queue, and from there
// it moves into the output register once that register is empty or being
// drained; m_tvalid then rises.
// A small queue sits between the framer and the turn tracker, so bytes keep
// flowing while a result waits. When the receiver stalls, the queue fills
// and only then is s_tready dropped.
// Reset (aresetn low, synchronous) returns the framer to hunting, empties
// the queue and output, and clears the stored yaw and the turn counter.
module imu_serial_frame_decoder
    import imufd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] frame_kind, [17:2] axis_x, [33:18] axis_y, [49:34] axis_z,
    // [81:50] turn_count, [87:82] zero
    output logic [87:0] m_tdata
);

    logic            push;
    imufd_item_t     push_item;
    logic            pop;
    imufd_item_t     q_item;
    imufd_q_status_t q_stat;
    imufd_item_t     out_item;
    logic [31:0]     out_turns;

    imufd_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_valid  (s_tvalid),
        .rx_byte   (s_tdata),
        .q_full    (q_stat.full),
        .rx_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    imufd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (q_item),
        .status    (q_stat)
    );

    imufd_turn_track u_turn (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_item    (q_item),
        .q_empty   (q_stat.empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .out_turns (out_turns)
    );

    assign m_tdata = {6'd0, out_turns, out_item.axis_z, out_item.axis_y,
                      out_item.axis_x, out_item.frame_kind};

    // The framer never writes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("queue overflow");

    // The tracker never reads from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("queue underflow");

    // A stalled result stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output register overwritten while stalled");

endmodule

### rtl/imufd_framer.sv
module imufd_framer
    import imufd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rx_valid,
    input  logic [7:0]      rx_byte,
    input  logic            q_full,
    output logic            rx_ready,
    output logic            push,
    output imufd_item_t     push_item
);

    localparam logic [POS_WIDTH-1:0] LAST_POS  = POS_WIDTH'(FRAME_LENGTH - 1);
    localparam logic [POS_WIDTH-1:0] STORE_END = POS_WIDTH'(STORE_DEPTH);

    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           store_reg [STORE_DEPTH];
    logic                 accept;
    logic                 hunting;
    logic [2:0]           store_idx;
    logic                 type_known;
    logic [1:0]           kind;

    assign rx_ready = !q_full;
    assign accept   = rx_valid && rx_ready;
    assign hunting  = (pos_reg == '0) || (pos_reg > LAST_POS);
    assign store_idx = 3'(pos_reg - 1'b1);

    // Classify the frame type byte.
    always_comb begin
        type_known = 1'b1;
        kind       = KIND_ACCEL;
        unique case (store_reg[0])
            TYPE_ACCEL: kind = KIND_ACCEL;
            TYPE_RATE:  kind = KIND_RATE;
            TYPE_ANGLE: kind = KIND_ANGLE;
            default:    type_known = 1'b0;
        endcase
    end

    // Position and checksum tracking.
    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        push     = 1'b0;
        if (accept) begin
            if (hunting) begin
                pos_next = '0;
                if (rx_byte == HEADER_BYTE) begin
                    sum_next = rx_byte;
                    pos_next = POS_WIDTH'(1);
                end
            end else if (pos_reg < LAST_POS) begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + 1'b1;
            end else begin
                pos_next = '0;
                push     = (rx_byte == sum_reg) && type_known;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            sum_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // Frame bytes 1 to 7 are kept; later bytes only feed the checksum.
    always_ff @(posedge aclk) begin
        if (accept && !hunting && pos_reg <= STORE_END) begin
            store_reg[store_idx] <= rx_byte;
        end
    end

    // Axes are little endian.
    assign push_item.frame_kind = kind;
    assign push_item.axis_x     = {store_reg[2], store_reg[1]};
    assign push_item.axis_y     = {store_reg[4], store_reg[3]};
    assign push_item.axis_z     = {store_reg[6], store_reg[5]};

endmodule

### rtl/imufd_queue.sv
module imufd_queue
    import imufd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  imufd_item_t     push_item,
    input  logic            pop,
    output imufd_item_t     pop_item,
    output imufd_q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    imufd_item_t      entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/imufd_turn_track.sv
module imufd_turn_track
    import imufd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  imufd_item_t     q_item,
    input  logic            q_empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output imufd_item_t     out_item,
    output logic [31:0]     out_turns
);

    logic        valid_reg, valid_next;
    imufd_item_t item_reg;
    logic [31:0] turns_reg, turns_next;
    logic [15:0] yaw_reg, yaw_next;
    logic [31:0] count_reg, count_next;
    logic        is_angle;
    logic        jump_up;
    logic        jump_down;

    // When the queue holds an item, load the output register whenever it is empty or being drained.
    assign pop      = !q_empty && (!valid_reg || out_ready);
    assign is_angle = (q_item.frame_kind == KIND_ANGLE);

    // Yaw crossing the 180 degree seam in either direction.
    assign jump_down = ($signed(yaw_reg) < YAW_NEG_LIMIT) &&
                       ($signed(q_item.axis_z) > YAW_POS_LIMIT);
    assign jump_up   = ($signed(yaw_reg) > YAW_POS_LIMIT) &&
                       ($signed(q_item.axis_z) < YAW_NEG_LIMIT);

    always_comb begin
        valid_next = valid_reg;
        yaw_next   = yaw_reg;
        count_next = count_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            valid_next = 1'b1;
            if (is_angle) begin
                yaw_next = q_item.axis_z;
                if (jump_down) begin
                    count_next = count_reg - 32'd1;
                end else if (jump_up) begin
                    count_next = count_reg + 32'd1;
                end
            end
        end
        turns_next = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            yaw_reg   <= '0;
            count_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            yaw_reg   <= yaw_next;
            count_reg <= count_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg  <= q_item;
            turns_reg <= turns_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_turns = turns_reg;

endmodule

### tb/tb_imu_serial_frame_decoder.sv
module tb_imu_serial_frame_decoder
    import imufd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch without any transaction before the run is declared hung.
    localparam int unsigned QUIET_LIMIT = 2000;
    // Cycles to wait after the last result, well over the result latency.
    localparam int unsigned TAIL_CYCLES = 20;
    // Input bytes for each random phase.
    localparam int unsigned PHASE_BYTES = 150;
    localparam int unsigned NUM_PROBES  = 20;
    localparam int unsigned MAX_REPORTS = 100;

    // One decoded frame as it should appear on the master stream.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [31:0] turns;
    } frame_result_t;

    // One directed frame. When typed is set, the result is given in the row
    // (axes equal to the row's axes) instead of being computed.
    typedef struct packed {
        logic        has_lead;
        logic [7:0]  lead;
        logic [7:0]  ftype;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [15:0] pad;
        logic        bad_sum;
        logic        typed;
        logic        t_hit;
        logic [1:0]  t_kind;
        logic [31:0] t_turn;
    } probe_row_t;

    localparam probe_row_t PROBE_ROWS [NUM_PROBES] = '{
        // Noise before the header, then axis extremes.
        '{1'b1, 8'h00, TYPE_ACCEL, 16'h7fff, 16'h8000, 16'h0000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ACCEL, 32'h0000_0000},
        '{1'b1, 8'hff, TYPE_RATE, 16'hffff, 16'h0001, 16'h8000, 16'hffff,
          1'b0, 1'b1, 1'b1, KIND_RATE, 32'h0000_0000},
        '{1'b1, 8'h54, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'h0000_0000},
        // Yaw walks across the seam in both directions.
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h1234, 16'hedcb, 16'hbfff, 16'h0102,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'h0000_0000},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h4001, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'hbfff, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'h0000_0000},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        // Exactly -90 and +90 degrees are not beyond the limit.
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'hc000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_fffe},
        // A bad checksum drops the frame and leaves the yaw alone.
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
          1'b1, 1'b1, 1'b0, KIND_ACCEL, 32'h0000_0000},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000,
          1'b0, 1'b1, 1'b1, KIND_ANGLE, 32'hffff_ffff},
        // Unknown types with a good checksum give nothing.
        '{1'b0, 8'h00, 8'h54, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
          1'b0, 1'b1, 1'b0, KIND_ACCEL, 32'h0000_0000},
        '{1'b0, 8'h00, 8'h00, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
          1'b0, 1'b1, 1'b0, KIND_ACCEL, 32'h0000_0000},
        '{1'b0, 8'h00, 8'hff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          1'b0, 1'b1, 1'b0, KIND_ACCEL, 32'h0000_0000},
        // Header bytes inside a broken frame must not resynchronize.
        '{1'b0, 8'h00, TYPE_ACCEL, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
          1'b1, 1'b1, 1'b0, KIND_ACCEL, 32'h0000_0000},
        '{1'b0, 8'h00, TYPE_RATE, 16'h55aa, 16'haa55, 16'h5555, 16'h0055,
          1'b0, 1'b0, 1'b0, KIND_ACCEL, 32'h0000_0000},
        // Non-angle frames carry the counter unchanged.
        '{1'b0, 8'h00, TYPE_ACCEL, 16'h0001, 16'h8001, 16'h7ffe, 16'h5555,
          1'b0, 1'b1, 1'b1, KIND_ACCEL, 32'hffff_ffff},
        '{1'b0, 8'h00, TYPE_ANGLE, 16'h3c3c, 16'hc3c3, 16'hc001, 16'ha5a5,
          1'b0, 1'b0, 1'b0, KIND_ACCEL, 32'h0000_0000}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [1:0] frame_kind, [17:2] axis_x, [33:18] axis_y, [49:34] axis_z,
    // [81:50] turn_count, [87:82] zero
    logic [87:0] m_tdata;

    // Decoder state mirrored by the testbench.
    logic [3:0]         fr_pos   = '0;
    logic [7:0]         fr_bytes [8] = '{default: 8'h00};
    logic [7:0]         fr_sum   = '0;
    logic signed [15:0] yaw_now  = '0;
    logic signed [15:0] yaw_last = '0;
    logic signed [31:0] turns    = '0;

    frame_result_t pending_frames [$];
    int unsigned   mismatches = 0;
    int unsigned   bytes_sent = 0;
    int unsigned   idle_pct   = 0;
    int unsigned   stall_pct  = 0;
    int unsigned   quiet      = 0;

    imu_serial_frame_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS) begin
            $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Advances the mirrored framer by one byte and tells whether a frame
    // completes with a result.
    task automatic decode_byte(input logic [7:0] b, output bit hit,
                               output frame_result_t res);
        logic [1:0] kind;
        bit         known;

        hit = 1'b0;
        res = '0;
        if (fr_pos == 0 || fr_pos > FRAME_LENGTH - 1) begin
            // Hunting for the header.
            fr_pos = '0;
            if (b == HEADER_BYTE) begin
                fr_sum = b;
                fr_pos = 4'd1;
            end
        end else if (fr_pos < FRAME_LENGTH - 1) begin
            if (fr_pos <= 8) begin
                fr_bytes[3'(fr_pos - 4'd1)] = b;
            end
            fr_sum = fr_sum + b;
            fr_pos = fr_pos + 4'd1;
        end else begin
            // Checksum byte ends the frame either way.
            fr_pos = '0;
            known  = 1'b1;
            kind   = KIND_ACCEL;
            case (fr_bytes[0])
                TYPE_ACCEL: kind = KIND_ACCEL;
                TYPE_RATE:  kind = KIND_RATE;
                TYPE_ANGLE: kind = KIND_ANGLE;
                default:    known = 1'b0;
            endcase
            if (b == fr_sum && known) begin
                res.kind = kind;
                res.ax   = {fr_bytes[2], fr_bytes[1]};
                res.ay   = {fr_bytes[4], fr_bytes[3]};
                res.az   = {fr_bytes[6], fr_bytes[5]};
                if (kind == KIND_ANGLE) begin
                    yaw_last = yaw_now;
                    yaw_now  = res.az;
                    if (yaw_last < YAW_NEG_LIMIT && yaw_now > YAW_POS_LIMIT) begin
                        turns = turns - 1;
                    end else if (yaw_last > YAW_POS_LIMIT && yaw_now < YAW_NEG_LIMIT) begin
                        turns = turns + 1;
                    end
                end
                res.turns = turns;
                hit = 1'b1;
            end
        end
    endtask

    // Presents one byte, waits for its transaction and records what it causes.
    // With quiet_push set, a result is left for the caller to supply.
    task automatic send_byte(input logic [7:0] b, input bit quiet_push);
        bit            hit;
        frame_result_t res;

        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        decode_byte(b, hit, res);
        if (hit && !quiet_push) begin
            pending_frames.push_back(res);
        end
    endtask

    // Sends the first cut bytes of a frame; a wrong checksum when bad_sum.
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] ax, ay, az,
                              input logic [15:0] pad, input bit bad_sum,
                              input int unsigned cut, input bit typed);
        logic [7:0] fb [FRAME_LENGTH];
        logic [7:0] sum;

        fb[0] = HEADER_BYTE;
        fb[1] = ftype;
        {fb[3], fb[2]} = ax;
        {fb[5], fb[4]} = ay;
        {fb[7], fb[6]} = az;
        {fb[9], fb[8]} = pad;
        sum = '0;
        for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
            sum = sum + fb[i];
        end
        fb[FRAME_LENGTH - 1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < cut; i++) begin
            send_byte(fb[i], typed);
        end
    endtask

    // Axis values lean toward the yaw limits and the extremes.
    function automatic logic [15:0] pick_axis();
        logic [15:0] near [4] = '{16'h4000, 16'h4001, 16'hc000, 16'hbfff};
        logic [15:0] ends [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 16'($urandom);
        end else if (r < 75) begin
            return near[2'($urandom_range(0, 3))];
        end
        return ends[2'($urandom_range(0, 3))];
    endfunction

    function automatic logic [7:0] pick_known_type();
        int unsigned r;

        r = $urandom_range(0, 3);
        if (r == 0) begin
            return TYPE_ACCEL;
        end else if (r == 1) begin
            return TYPE_RATE;
        end
        return TYPE_ANGLE;
    endfunction

    // One random stimulus step: mostly good frames, the rest broken or noise.
    task automatic send_random_step();
        int unsigned r;
        logic [7:0]  ftype;

        r = $urandom_range(0, 99);
        if (r < 70) begin
            send_frame(pick_known_type(), pick_axis(), pick_axis(), pick_axis(),
                       16'($urandom), 1'b0, FRAME_LENGTH, 1'b0);
        end else if (r < 78) begin
            send_frame(pick_known_type(), pick_axis(), pick_axis(), pick_axis(),
                       16'($urandom), 1'b1, FRAME_LENGTH, 1'b0);
        end else if (r < 84) begin
            do ftype = 8'($urandom);
            while (ftype == TYPE_ACCEL || ftype == TYPE_RATE || ftype == TYPE_ANGLE);
            send_frame(ftype, pick_axis(), pick_axis(), pick_axis(),
                       16'($urandom), 1'b0, FRAME_LENGTH, 1'b0);
        end else if (r < 92) begin
            repeat ($urandom_range(1, 4)) begin
                send_byte(($urandom_range(0, 7) == 0) ? HEADER_BYTE : 8'($urandom), 1'b0);
            end
        end else begin
            // Truncated frame: the bytes after it are taken as its tail.
            send_frame(pick_known_type(), pick_axis(), pick_axis(), pick_axis(),
                       16'($urandom), 1'b0, $urandom_range(2, 10), 1'b0);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_frames.size() != 0);
    endtask

    // Receiver side: random stalls and result checking.
    always @(posedge aclk) begin : result_check
        frame_result_t want;

        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[31:0], '0);
            end else begin
                want = pending_frames.pop_front();
                if (m_tdata[1:0] != want.kind) begin
                    report_mismatch("frame_kind", 32'(m_tdata[1:0]), 32'(want.kind));
                end
                if (m_tdata[17:2] != want.ax) begin
                    report_mismatch("axis_x", 32'(m_tdata[17:2]), 32'(want.ax));
                end
                if (m_tdata[33:18] != want.ay) begin
                    report_mismatch("axis_y", 32'(m_tdata[33:18]), 32'(want.ay));
                end
                if (m_tdata[49:34] != want.az) begin
                    report_mismatch("axis_z", 32'(m_tdata[49:34]), 32'(want.az));
                end
                if (m_tdata[81:50] != want.turns) begin
                    report_mismatch("turn_count", m_tdata[81:50], want.turns);
                end
                if (m_tdata[87:82] != '0) begin
                    report_mismatch("padding", 32'(m_tdata[87:82]), '0);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hang detection: too long without a transaction on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned idle_set  [4] = '{0, 65, 0, 15};
        int unsigned stall_set [4] = '{0, 0, 65, 15};
        int unsigned phase_end;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames, back to back.
        foreach (PROBE_ROWS[i]) begin
            if (PROBE_ROWS[i].has_lead) begin
                send_byte(PROBE_ROWS[i].lead, 1'b0);
            end
            send_frame(PROBE_ROWS[i].ftype, PROBE_ROWS[i].ax, PROBE_ROWS[i].ay,
                       PROBE_ROWS[i].az, PROBE_ROWS[i].pad, PROBE_ROWS[i].bad_sum,
                       FRAME_LENGTH, PROBE_ROWS[i].typed);
            if (PROBE_ROWS[i].typed && PROBE_ROWS[i].t_hit) begin
                pending_frames.push_back('{PROBE_ROWS[i].t_kind, PROBE_ROWS[i].ax,
                                           PROBE_ROWS[i].ay, PROBE_ROWS[i].az,
                                           PROBE_ROWS[i].t_turn});
            end
        end

        // Random phases; the sender pauses for all results between phases.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                send_random_step();
            end
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/imufd_pkg.sv
rtl/imufd_framer.sv
rtl/imufd_queue.sv
rtl/imufd_turn_track.sv
rtl/imu_serial_frame_decoder.sv
tb/tb_imu_serial_frame_decoder.sv
